// ===== design/rcfsm_pkg.sv =====
package rcfsm_pkg;

   // request codes carried on the input channel
   typedef enum logic [1:0] {
      REQ_COMMAND    = 2'd0,
      REQ_CONNECT    = 2'd1,
      REQ_DISCONNECT = 2'd2,
      REQ_TICK       = 2'd3
   } req_code_type;

   // effective timing limits after defaulting and clamping
   typedef struct packed {
      logic [15:0] interval_ms;
      logic [19:0] move_ms;
      logic [23:0] emergency_ms;
   } limits_type;

   // one result item
   typedef struct packed {
      logic [10:0] pulse_us;
      logic [7:0]  angle;
      logic        move_led;
      logic        link_led;
   } result_type;

   localparam logic [10:0] PULSE_MIN       = 11'd1000;
   localparam logic [10:0] PULSE_MAX       = 11'd2000;
   localparam logic [10:0] PULSE_CRAWL     = 11'd1172;
   localparam logic [10:0] PULSE_BASE      = 11'd1080;
   localparam logic [7:0]  ANGLE_NEUTRAL   = 8'd85;
   localparam logic [7:0]  ANGLE_RESET     = 8'd70;
   localparam logic [15:0] INTERVAL_MIN    = 16'd50;
   localparam logic [15:0] INTERVAL_RESET  = 16'd50;
   localparam logic [19:0] MOVE_RESET      = 20'd600;
   localparam logic [23:0] EMERGENCY_RESET = 24'd240000;

endpackage

// ===== design/rc_command_failsafe_servo_mapper_unit.sv =====
// Command failsafe servo mapper.
// Input channel (req_*): one item per command, link connect, link disconnect
// or one-millisecond tick, taken when req_valid is high and req_stall low.
// Result channel (rsp_*): one item per tick carrying the throttle pulse
// width, rudder angle and the two lamp states; other items give no result.
// Configuration (psel/penable/pwrite/paddr/pwdata): refresh interval at
// byte address 0, move timeout at 4, emergency timeout at 8; write only
// while the block is idle. pready is always high, reads return the value.
// An accepted item is held in the input register; a tick then moves its
// result into the output register, which raises rsp_valid and holds the
// result until it is taken.
// Throughput: one item per cycle, ticks back to back included, as long as
// rsp_stall is low.
// While rsp_stall holds a result, non-tick items keep flowing; a tick waits
// in the input register and req_stall rises until the result is taken.
// Reset (synchronous) empties both registers, restores the register
// defaults, sets the held pulse to minimum and the angle to 70, link down.
module rc_command_failsafe_servo_mapper_unit (
   input  logic              clock,
   input  logic              reset,
   // input channel
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [1:0]        req_type,
   input  logic signed [7:0] req_steer_x,
   input  logic signed [7:0] req_throttle_y,
   input  logic              req_user_active,
   // result channel
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [10:0]       rsp_throttle_pulse_us,
   output logic [7:0]        rsp_helm_angle,
   output logic              rsp_move_led,
   output logic              rsp_link_led,
   // configuration port
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [3:0]        paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);

   logic                  s1_valid_ff, s1_valid_in;
   logic [1:0]            s1_type_ff;
   logic signed [7:0]     s1_steer_ff;
   logic signed [7:0]     s1_throttle_ff;
   logic                  s1_active_ff;
   logic                  s1_is_tick;
   logic                  s1_go;
   logic                  out_valid_ff, out_valid_in;
   rcfsm_pkg::result_type out_ff;
   rcfsm_pkg::result_type core_result;
   rcfsm_pkg::limits_type limits;

   rcfsm_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .limits  (limits)
   );

   // an item leaves the input register unless it is a tick facing a full, stalled output
   assign s1_is_tick = (s1_type_ff == rcfsm_pkg::REQ_TICK);
   assign s1_go      = s1_valid_ff && (!s1_is_tick || !out_valid_ff || !rsp_stall);
   assign req_stall  = s1_valid_ff && !s1_go;

   rcfsm_core u_core (
      .clock       (clock),
      .reset       (reset),
      .fire        (s1_go),
      .item_type   (s1_type_ff),
      .steer_x     (s1_steer_ff),
      .throttle_y  (s1_throttle_ff),
      .user_active (s1_active_ff),
      .limits      (limits),
      .result      (core_result)
   );

   // input register
   assign s1_valid_in = req_stall ? s1_valid_ff : req_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall) begin
         s1_type_ff     <= req_type;
         s1_steer_ff    <= req_steer_x;
         s1_throttle_ff <= req_throttle_y;
         s1_active_ff   <= req_user_active;
      end
   end

   // output register
   always_comb begin
      if (s1_go && s1_is_tick) begin
         out_valid_in = 1'b1;
      end else if (out_valid_ff && !rsp_stall) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_go && s1_is_tick) begin
         out_ff <= core_result;
      end
   end

   assign rsp_valid             = out_valid_ff;
   assign rsp_throttle_pulse_us = out_ff.pulse_us;
   assign rsp_helm_angle        = out_ff.angle;
   assign rsp_move_led          = out_ff.move_led;
   assign rsp_link_led          = out_ff.link_led;

endmodule

// ===== design/rcfsm_csr.sv =====
module rcfsm_csr (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    psel,
   input  logic                    penable,
   input  logic                    pwrite,
   input  logic [3:0]              paddr,
   input  logic [31:0]             pwdata,
   output logic [31:0]             prdata,
   output logic                    pready,
   output rcfsm_pkg::limits_type   limits
);

   localparam logic [1:0] IDX_INTERVAL  = 2'd0;
   localparam logic [1:0] IDX_MOVE      = 2'd1;
   localparam logic [1:0] IDX_EMERGENCY = 2'd2;

   logic [15:0] interval_ff;
   logic [19:0] move_ff;
   logic [23:0] emergency_ff;
   logic        wr_en;
   logic [1:0]  idx;
   logic [15:0] interval_eff;
   logic [16:0] twice_interval;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite;
   assign idx    = paddr[3:2];

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         interval_ff  <= rcfsm_pkg::INTERVAL_RESET;
         move_ff      <= rcfsm_pkg::MOVE_RESET;
         emergency_ff <= rcfsm_pkg::EMERGENCY_RESET;
      end else if (wr_en) begin
         case (idx)
            IDX_INTERVAL:  interval_ff  <= pwdata[15:0];
            IDX_MOVE:      move_ff      <= pwdata[19:0];
            IDX_EMERGENCY: emergency_ff <= pwdata[23:0];
            default: ;
         endcase
      end
   end

   // register reads
   always_comb begin
      case (idx)
         IDX_INTERVAL:  prdata = {16'd0, interval_ff};
         IDX_MOVE:      prdata = {12'd0, move_ff};
         IDX_EMERGENCY: prdata = {8'd0, emergency_ff};
         default:       prdata = 32'd0;
      endcase
   end

   // effective limits: interval floor, move timeout floor, emergency default
   assign interval_eff   = (interval_ff < rcfsm_pkg::INTERVAL_MIN) ?
                           rcfsm_pkg::INTERVAL_MIN : interval_ff;
   assign twice_interval = {interval_eff, 1'b0};

   always_comb begin
      limits.interval_ms = interval_eff;
      limits.move_ms     = ({3'd0, twice_interval} > move_ff) ?
                           {3'd0, twice_interval} : move_ff;
      limits.emergency_ms = (emergency_ff == 24'd0) ?
                            rcfsm_pkg::EMERGENCY_RESET : emergency_ff;
   end

endmodule

// ===== design/rcfsm_core.sv =====
module rcfsm_core (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    fire,
   input  logic [1:0]              item_type,
   input  logic signed [7:0]       steer_x,
   input  logic signed [7:0]       throttle_y,
   input  logic                    user_active,
   input  rcfsm_pkg::limits_type   limits,
   output rcfsm_pkg::result_type   result
);

   logic              link_up_ff, link_up_in;
   logic              cmd_seen_ff, cmd_seen_in;
   logic [31:0]       elapsed_ff, elapsed_in;
   logic              refreshed_ff, refreshed_in;
   logic signed [7:0] steer_ff, steer_in;
   logic signed [7:0] throttle_ff, throttle_in;
   logic              active_ff, active_in;
   logic [10:0]       pulse_ff, pulse_in;
   logic [7:0]        angle_ff, angle_in;
   logic              lamp_ff, lamp_in;

   logic [31:0]       elapsed_inc;
   logic [10:0]       map_pulse;
   logic [7:0]        map_angle;

   // throttle percent to pulse width: d*920/50 as d*18.4 via fixed point
   logic [5:0]        thr_d;
   logic [26:0]       thr_prod;
   // rudder percent to angle
   logic signed [7:0] rud_v;
   logic [6:0]        rud_pos;
   logic [26:0]       rud_pos_prod;
   logic [7:0]        rud_neg;
   logic [27:0]       rud_neg_prod;

   assign thr_d    = 6'(throttle_ff - 8'sd20);
   assign thr_prod = 27'(thr_d) * 27'd1205863;

   always_comb begin
      if (throttle_ff < 8'sd20) begin
         map_pulse = rcfsm_pkg::PULSE_MIN;
      end else if (throttle_ff > 8'sd70) begin
         map_pulse = rcfsm_pkg::PULSE_MAX;
      end else begin
         map_pulse = rcfsm_pkg::PULSE_BASE + 11'(thr_prod[26:16]);
      end
   end

   // saturate steering, then v*55/100+85 or (v+100)*84/100+1
   always_comb begin
      if (steer_ff > 8'sd100) begin
         rud_v = 8'sd100;
      end else if (steer_ff < -8'sd100) begin
         rud_v = -8'sd100;
      end else begin
         rud_v = steer_ff;
      end
   end

   assign rud_pos      = rud_v[6:0];
   assign rud_pos_prod = 27'(rud_pos) * 27'd576730;
   assign rud_neg      = 8'(rud_v + 8'sd100);
   assign rud_neg_prod = 28'(rud_neg) * 28'd880804;

   always_comb begin
      if (rud_v[7] == 1'b0) begin
         map_angle = rcfsm_pkg::ANGLE_NEUTRAL + 8'(rud_pos_prod[26:20]);
      end else begin
         map_angle = 8'd1 + 8'(rud_neg_prod[27:20]);
      end
   end

   assign elapsed_inc = (elapsed_ff == 32'hFFFF_FFFF) ? elapsed_ff : elapsed_ff + 32'd1;

   // next state per item
   always_comb begin
      link_up_in   = link_up_ff;
      cmd_seen_in  = cmd_seen_ff;
      elapsed_in   = elapsed_ff;
      refreshed_in = refreshed_ff;
      steer_in     = steer_ff;
      throttle_in  = throttle_ff;
      active_in    = active_ff;
      pulse_in     = pulse_ff;
      angle_in     = angle_ff;
      lamp_in      = lamp_ff;
      case (rcfsm_pkg::req_code_type'(item_type))
         rcfsm_pkg::REQ_COMMAND: begin
            steer_in     = steer_x;
            throttle_in  = throttle_y;
            active_in    = user_active;
            cmd_seen_in  = 1'b1;
            elapsed_in   = 32'd0;
            refreshed_in = 1'b0;
         end
         rcfsm_pkg::REQ_CONNECT: begin
            link_up_in  = 1'b1;
            cmd_seen_in = 1'b0;
         end
         rcfsm_pkg::REQ_DISCONNECT: begin
            link_up_in = 1'b0;
         end
         rcfsm_pkg::REQ_TICK: begin
            elapsed_in = elapsed_inc;
            if (!cmd_seen_ff) begin
               pulse_in = rcfsm_pkg::PULSE_MIN;
               angle_in = rcfsm_pkg::ANGLE_NEUTRAL;
            end else if (elapsed_inc > {8'd0, limits.emergency_ms}) begin
               lamp_in      = 1'b0;
               refreshed_in = 1'b0;
               pulse_in     = rcfsm_pkg::PULSE_CRAWL;
            end else if (!link_up_ff) begin
               // hold outputs and refresh state while the link is down; elapsed still counts
            end else if (elapsed_inc < {16'd0, limits.interval_ms} && refreshed_ff) begin
               // too early for a refresh
            end else if (elapsed_inc > {12'd0, limits.move_ms}) begin
               lamp_in      = 1'b0;
               refreshed_in = 1'b0;
               pulse_in     = rcfsm_pkg::PULSE_MIN;
               angle_in     = rcfsm_pkg::ANGLE_NEUTRAL;
            end else begin
               pulse_in     = map_pulse;
               angle_in     = map_angle;
               refreshed_in = 1'b1;
               lamp_in      = active_ff;
            end
         end
         default: ;
      endcase
   end

   // state registers, updated when an item leaves the input register
   always_ff @(posedge clock) begin
      if (reset) begin
         link_up_ff   <= 1'b0;
         cmd_seen_ff  <= 1'b0;
         elapsed_ff   <= 32'd0;
         refreshed_ff <= 1'b0;
         steer_ff     <= 8'sd0;
         throttle_ff  <= 8'sd0;
         active_ff    <= 1'b0;
         pulse_ff     <= rcfsm_pkg::PULSE_MIN;
         angle_ff     <= rcfsm_pkg::ANGLE_RESET;
         lamp_ff      <= 1'b0;
      end else if (fire) begin
         link_up_ff   <= link_up_in;
         cmd_seen_ff  <= cmd_seen_in;
         elapsed_ff   <= elapsed_in;
         refreshed_ff <= refreshed_in;
         steer_ff     <= steer_in;
         throttle_ff  <= throttle_in;
         active_ff    <= active_in;
         pulse_ff     <= pulse_in;
         angle_ff     <= angle_in;
         lamp_ff      <= lamp_in;
      end
   end

   // result of a tick, taken by the output register
   always_comb begin
      result.pulse_us = pulse_in;
      result.angle    = angle_in;
      result.move_led = lamp_in;
      result.link_led = link_up_ff;
   end

endmodule

// ===== design/rcfsm_checker.sv =====
module rcfsm_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input logic [10:0]       rsp_throttle_pulse_us,
   input logic [7:0]        rsp_helm_angle,
   input logic              rsp_move_led,
   input logic              rsp_link_led,
   input logic              psel,
   input logic              penable,
   input logic              pready
);

   // a stalled result item holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_throttle_pulse_us)
         && $stable(rsp_helm_angle) && $stable(rsp_move_led) && $stable(rsp_link_led))
      else $error("stalled result item changed");

   // pulse and angle stay inside the servo ranges
   a_rsp_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_throttle_pulse_us >= 11'd1000 && rsp_throttle_pulse_us <= 11'd2000
         && rsp_helm_angle >= 8'd1 && rsp_helm_angle <= 8'd140)
      else $error("result item out of range");

   // reset empties the output register
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result item present after reset");

   // input is only held back by a waiting result item
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled without a blocked result item");

   // configuration port is always ready
   a_pready: assert property (@(posedge clock) disable iff (reset)
      psel && penable |-> pready)
      else $error("configuration access not ready");

endmodule

bind rc_command_failsafe_servo_mapper_unit rcfsm_checker u_rcfsm_checker (.*);
